### sv/mmt_pkg.sv
// Package: shared types, register codes, reset values and compare helpers for the motion tracker.
`timescale 1ns / 1ps
`default_nettype none

package mmt_pkg;

    // Sample word and history stores
    typedef logic signed [15:0] t_word;
    typedef t_word [3:0]        t_hist4;
    typedef t_word [7:0]        t_hist8;
    typedef logic [14:0]        t_tol;

    // Register file index codes (byte address = 4 * index)
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_THRESHOLD   = 3'd0;
    localparam logic [2:0] REG_HYSTERESIS  = 3'd1;
    localparam logic [2:0] REG_MIN_LEVEL   = 3'd2;
    localparam logic [2:0] REG_ZERO_TOL    = 3'd3;
    localparam logic [2:0] REG_SLEEP_ENTER = 3'd4;
    localparam logic [2:0] REG_SLEEP_EXIT  = 3'd5;
    localparam logic [2:0] REG_HALT_TOL    = 3'd6;

    // Reset values of the tolerances
    localparam t_tol ZERO_TOL_RST    = 15'd10;
    localparam t_tol SLEEP_ENTER_RST = 15'd3;
    localparam t_tol SLEEP_EXIT_RST  = 15'd10;
    localparam t_tol HALT_TOL_RST    = 15'd3;

    // Configuration handed from the register file to the datapath
    typedef struct packed {
        logic signed [15:0] threshold;
        logic signed [7:0]  hysteresis;
        logic signed [15:0] min_level;
        t_tol               zero_tol;
        t_tol               sleep_enter_tol;
        t_tol               sleep_exit_tol;
        t_tol               halt_tol;
    } t_cfg;

    // Result item
    typedef struct packed {
        logic  rezeroed;
        t_word offset;
        logic  sleep;
        logic  halt;
        logic  condition;
    } t_res;

    // |a - b| <= t, worked out on 17 bits so nothing wraps
    function automatic logic near(input t_word a, input t_word b, input t_tol t);
        logic signed [16:0] d;
        logic [16:0]        mag;
        d   = {a[15], a} - {b[15], b};
        mag = d[16] ? 17'(-d) : 17'(d);
        return mag <= {2'b00, t};
    endfunction

    // All checked middle pairs (0,1) (1,2) (2,3) (0,3) within t
    function automatic logic mid_within(input t_hist4 m, input t_tol t);
        return near(m[0], m[1], t) && near(m[1], m[2], t) &&
               near(m[2], m[3], t) && near(m[0], m[3], t);
    endfunction

endpackage

`default_nettype wire

### sv/mmt_if.sv
// Interfaces: sample input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none

interface mmt_in_if;
    logic          valid;
    logic          ready;
    mmt_pkg::t_word sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mmt_out_if;
    logic          valid;
    logic          ready;
    logic          rezeroed;
    mmt_pkg::t_word offset;
    logic          sleep;
    logic          halt;
    logic          condition;

    modport source (output valid, output rezeroed, output offset, output sleep,
                    output halt, output condition, input ready);
    modport sink   (input valid, input rezeroed, input offset, input sleep,
                    input halt, input condition, output ready);
endinterface

`default_nettype wire

### sv/mmt_regs.sv
// APB-style register file holding the tracker configuration.
`timescale 1ns / 1ps
`default_nettype none

module mmt_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mmt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output mmt_pkg::t_cfg                   o_cfg
);

    mmt_pkg::t_cfg r_cfg;
    logic [2:0]    w_idx;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[mmt_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold       <= '0;
            r_cfg.hysteresis      <= '0;
            r_cfg.min_level       <= '0;
            r_cfg.zero_tol        <= mmt_pkg::ZERO_TOL_RST;
            r_cfg.sleep_enter_tol <= mmt_pkg::SLEEP_ENTER_RST;
            r_cfg.sleep_exit_tol  <= mmt_pkg::SLEEP_EXIT_RST;
            r_cfg.halt_tol        <= mmt_pkg::HALT_TOL_RST;
        end else if (w_wr) begin
            case (w_idx)
                mmt_pkg::REG_THRESHOLD:   r_cfg.threshold       <= pwdata[15:0];
                mmt_pkg::REG_HYSTERESIS:  r_cfg.hysteresis      <= pwdata[7:0];
                mmt_pkg::REG_MIN_LEVEL:   r_cfg.min_level       <= pwdata[15:0];
                mmt_pkg::REG_ZERO_TOL:    r_cfg.zero_tol        <= pwdata[14:0];
                mmt_pkg::REG_SLEEP_ENTER: r_cfg.sleep_enter_tol <= pwdata[14:0];
                mmt_pkg::REG_SLEEP_EXIT:  r_cfg.sleep_exit_tol  <= pwdata[14:0];
                mmt_pkg::REG_HALT_TOL:    r_cfg.halt_tol        <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // read-back, sign-extended where signed
    always_comb begin
        case (w_idx)
            mmt_pkg::REG_THRESHOLD:   prdata = {{16{r_cfg.threshold[15]}}, r_cfg.threshold};
            mmt_pkg::REG_HYSTERESIS:  prdata = {{24{r_cfg.hysteresis[7]}}, r_cfg.hysteresis};
            mmt_pkg::REG_MIN_LEVEL:   prdata = {{16{r_cfg.min_level[15]}}, r_cfg.min_level};
            mmt_pkg::REG_ZERO_TOL:    prdata = {17'd0, r_cfg.zero_tol};
            mmt_pkg::REG_SLEEP_ENTER: prdata = {17'd0, r_cfg.sleep_enter_tol};
            mmt_pkg::REG_SLEEP_EXIT:  prdata = {17'd0, r_cfg.sleep_exit_tol};
            mmt_pkg::REG_HALT_TOL:    prdata = {17'd0, r_cfg.halt_tol};
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### sv/mmt_core.sv
// Datapath: input register, history stores, flag logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module mmt_core (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire mmt_pkg::t_cfg i_cfg,
    mmt_in_if.sink       i_in,
    mmt_out_if.source    o_out
);

    // input stage
    logic           r_iv;
    mmt_pkg::t_word r_samp;
    // result stage
    logic           r_ov;
    mmt_pkg::t_res  r_res;
    // tracker state
    logic [7:0]     r_count;
    logic [2:0]     r_slow_idx;
    mmt_pkg::t_hist4 r_fast, r_mid;
    mmt_pkg::t_hist8 r_slow;
    mmt_pkg::t_word r_zero;
    logic           r_sleep, r_halt, r_cond;

    mmt_pkg::t_hist4 n_fast, n_mid;
    mmt_pkg::t_hist8 n_slow;
    mmt_pkg::t_word n_zero;
    logic           n_sleep, n_halt, n_cond;
    logic           w_slow_wr, w_zero_ok, w_flat, w_fast_ok, w_gt, w_lt;
    logic signed [17:0] w_sum, w_sum_adj;
    logic signed [16:0] w_thr_h;
    logic           w_adv;

    // handshake: input stage moves on when the result register is free or drains
    assign w_adv      = r_iv && (!r_ov || o_out.ready);
    assign i_in.ready = !r_iv || w_adv;

    assign o_out.valid      = r_ov;
    assign o_out.rezeroed   = r_res.rezeroed;
    assign o_out.offset     = r_res.offset;
    assign o_out.sleep      = r_res.sleep;
    assign o_out.halt       = r_res.halt;
    assign o_out.condition  = r_res.condition;

    // store updates for the item in the input register
    always_comb begin
        n_fast = r_fast;
        n_mid  = r_mid;
        n_slow = r_slow;
        if (!r_count[0]) n_fast[r_count[2:1]] = r_samp;
        if (r_count[5:0] == 6'd0) n_mid[r_count[7:6]] = r_samp;
        w_slow_wr = (r_count == 8'd0);
        if (w_slow_wr) n_slow[r_slow_idx] = r_samp;
    end

    // zero re-estimate: mean of middle entries, truncated toward zero
    always_comb begin
        w_sum = 18'(signed'(n_mid[0])) + 18'(signed'(n_mid[1]))
              + 18'(signed'(n_mid[2])) + 18'(signed'(n_mid[3]));
        w_sum_adj = w_sum + (w_sum[17] ? 18'sd3 : 18'sd0);
        w_zero_ok = w_slow_wr && mmt_pkg::mid_within(n_mid, i_cfg.zero_tol);
        n_zero    = w_zero_ok ? w_sum_adj[17:2] : r_zero;
    end

    // sleep with separate enter and exit tolerances
    always_comb begin
        if (mmt_pkg::mid_within(n_mid, i_cfg.sleep_enter_tol)) n_sleep = 1'b1;
        else if (!mmt_pkg::mid_within(n_mid, i_cfg.sleep_exit_tol)) n_sleep = 1'b0;
        else n_sleep = r_sleep;
    end

    // sticky halt: slow neighbours flat and last entry nonzero
    always_comb begin
        w_flat = 1'b1;
        for (int i = 0; i < 7; i++) begin
            if (!mmt_pkg::near(n_slow[i], n_slow[i+1], i_cfg.halt_tol)) w_flat = 1'b0;
        end
        n_halt = r_halt || (w_flat && (n_slow[7] != 16'sd0));
    end

    // hysteresis threshold condition
    always_comb begin
        w_thr_h   = {i_cfg.threshold[15], i_cfg.threshold}
                  + {{9{i_cfg.hysteresis[7]}}, i_cfg.hysteresis};
        w_gt      = $signed({r_samp[15], r_samp}) > w_thr_h;
        w_lt      = $signed(r_samp) < $signed(i_cfg.threshold);
        w_fast_ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (!($signed(n_fast[i]) > $signed(i_cfg.min_level))) w_fast_ok = 1'b0;
        end
        if (w_gt && w_fast_ok) n_cond = 1'b1;
        else if (w_lt) n_cond = 1'b0;
        else n_cond = r_cond;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in.ready) begin
            r_iv <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) r_samp <= i_in.sample;
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov       <= 1'b0;
            r_count    <= '0;
            r_slow_idx <= '0;
            r_fast     <= '0;
            r_mid      <= '0;
            r_slow     <= '0;
            r_zero     <= '0;
            r_sleep    <= 1'b0;
            r_halt     <= 1'b0;
            r_cond     <= 1'b0;
        end else begin
            if (w_adv) begin
                r_ov       <= 1'b1;
                r_count    <= r_count + 8'd1;
                r_slow_idx <= w_slow_wr ? r_slow_idx + 3'd1 : r_slow_idx;
                r_fast     <= n_fast;
                r_mid      <= n_mid;
                r_slow     <= n_slow;
                r_zero     <= n_zero;
                r_sleep    <= n_sleep;
                r_halt     <= n_halt;
                r_cond     <= n_cond;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (w_adv) begin
            r_res.rezeroed   <= w_zero_ok;
            r_res.offset     <= n_zero;
            r_res.sleep      <= n_sleep;
            r_res.halt       <= n_halt;
            r_res.condition  <= n_cond;
        end
    end

`ifndef SYNTHESIS
    // slow index steps exactly on the wrap of the item count
    a_slow_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_count == 8'd0) |=> r_slow_idx == $past(r_slow_idx) + 3'd1)
        else $error("slow index did not advance on count wrap");
    // halt never drops once set
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");
    // a re-estimate is only reported for the item at count zero
    a_rezero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_count != 8'd0) |=> !r_res.rezeroed)
        else $error("re-zero flag off the slow write");
    // a held input item is not lost while the result stage is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iv && !w_adv |=> r_iv && $stable(r_samp))
        else $error("input stage item dropped");
`endif

endmodule

`default_nettype wire

### sv/multirate_motion_tracker.sv
// Top level of the multirate motion tracker: register file and datapath.
//
// Usage:
//   i_in carries one signed 16-bit acceleration sample per item (valid/ready).
//   o_out returns one result item per sample: rezeroed, offset, sleep,
//   halt and condition, in input order.
//   The APB-style port holds seven registers at byte addresses 0x00..0x18;
//   pready is tied high and writes take effect at the access cycle.
//   Pipeline: the sample sits in an input register, then a single pass of
//   store updates and compares fills the result register. Throughput is
//   one item per cycle while the receiver does not stall, set by the
//   single pass of the history update and flag logic.
//   When the receiver stalls, the result register holds and the input
//   register takes one further item; ready then drops until the result
//   drains.
//   Synchronous reset clears the item count, slow index, all three history
//   stores, the zero level and the flags, and loads the register defaults.
//   Configure only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module multirate_motion_tracker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    mmt_in_if.sink                          i_in,
    mmt_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mmt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    mmt_pkg::t_cfg w_cfg;

    // configuration registers
    mmt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sample datapath
    mmt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### test/testbench.sv
// Testbench: drives samples and register writes into the motion tracker and checks every result.
`timescale 1ns / 1ps

module testbench;
    import mmt_pkg::*;

    localparam int         RESULT_LATENCY = 2;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         LONG_HOLD      = 48;
    // five phases of this size bring the run to about 1400 items
    localparam int         PHASE_ITEMS    = 275;
    localparam logic [2:0] REG_SPARE      = 3'd7;

    // opening items: field extremes, a first zero estimate, condition set and clear
    localparam t_word OPENING [23] = '{
        16'sd5, 16'sh8000, 16'sh7FFF, 16'sd0, 16'shFFFF, 16'sd1,
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        16'shFFFF, 16'sd0, 16'sd1, 16'sh8000, 16'sh5555, 16'shAAAA,
        16'sh00FF, 16'shFF00, 16'sh7FFF, 16'sh0001
    };

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic  in_valid  = 1'b0;
    t_word in_sample = '0;
    logic  in_took   = 1'b0;
    logic  out_ready = 1'b0;

    mmt_in_if  in_ch ();
    mmt_out_if out_ch ();

    assign in_ch.valid  = in_valid;
    assign in_ch.sample = in_sample;
    assign out_ch.ready = out_ready;

    multirate_motion_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Samples waiting to be offered, and the reports they are due to produce
    t_word pending_samples [$];
    t_res  due_reports [$];

    // Register copy and tracker state as the checker sees them
    t_cfg       cfg_now;
    logic [7:0] trk_count    = '0;
    logic [2:0] trk_slow_idx = '0;
    t_word      trk_fast [4] = '{default: '0};
    t_word      trk_mid [4]  = '{default: '0};
    t_word      trk_slow [8] = '{default: '0};
    t_word      trk_zero     = '0;
    logic       trk_sleep    = 1'b0;
    logic       trk_halt     = 1'b0;
    logic       trk_cond     = 1'b0;

    // Stimulus shaping
    int         idle_pct    = 0;
    bit         want_hold   = 1'b0;
    logic [7:0] gen_pos     = '0;
    int         quiet_level = 0;
    int         noise_amp   = 0;

    int send_gap   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    int mismatches = 0;
    int cycles     = 0;

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // |a - b| <= tol on int, so nothing wraps
    function automatic bit within_tol(input t_word a, input t_word b, input int tol);
        int d;
        d = int'(a) - int'(b);
        if (d < 0) d = -d;
        return d <= tol;
    endfunction

    function automatic bit mid_quiet(input int tol);
        return within_tol(trk_mid[0], trk_mid[1], tol) && within_tol(trk_mid[1], trk_mid[2], tol) &&
               within_tol(trk_mid[2], trk_mid[3], tol) && within_tol(trk_mid[0], trk_mid[3], tol);
    endfunction

    // Advance the tracker state by one sample and queue the report it gives
    task automatic track_sample(input t_word s);
        t_res rep;
        int   sum;
        int   min_lvl;
        bit   flat;
        bit   above;
        rep.rezeroed = 1'b0;
        if (!trk_count[0]) trk_fast[trk_count[2:1]] = s;
        if (trk_count[5:0] == 6'd0) trk_mid[trk_count[7:6]] = s;
        if (trk_count == 8'd0) begin
            trk_slow[trk_slow_idx] = s;
            if (mid_quiet(int'(cfg_now.zero_tol))) begin
                sum = int'(trk_mid[0]) + int'(trk_mid[1]) + int'(trk_mid[2]) + int'(trk_mid[3]);
                // integer division truncates toward zero
                trk_zero     = t_word'(sum / 4);
                rep.rezeroed = 1'b1;
            end
            trk_slow_idx = trk_slow_idx + 3'd1;
        end
        trk_count = trk_count + 8'd1;

        // sleep: enter on tight middle history, leave on any wide pair
        if (mid_quiet(int'(cfg_now.sleep_enter_tol)))
            trk_sleep = 1'b1;
        else if (!mid_quiet(int'(cfg_now.sleep_exit_tol)))
            trk_sleep = 1'b0;

        // halt is sticky once the slow history is flat and its last entry nonzero
        flat = 1'b1;
        for (int i = 0; i < 7; i++)
            if (!within_tol(trk_slow[i], trk_slow[i + 1], int'(cfg_now.halt_tol))) flat = 1'b0;
        if (flat && trk_slow[7] != 0) trk_halt = 1'b1;

        // hysteresis condition
        min_lvl = int'($signed(cfg_now.min_level));
        above   = 1'b1;
        for (int i = 0; i < 4; i++)
            if (int'(trk_fast[i]) <= min_lvl) above = 1'b0;
        if (int'(s) > int'($signed(cfg_now.threshold)) + int'($signed(cfg_now.hysteresis)) && above)
            trk_cond = 1'b1;
        else if (int'(s) < int'($signed(cfg_now.threshold)))
            trk_cond = 1'b0;

        rep.offset     = trk_zero;
        rep.sleep      = trk_sleep;
        rep.halt       = trk_halt;
        rep.condition  = trk_cond;
        due_reports.push_back(rep);
    endtask

    task automatic check_field(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Monitor: check results against the oldest due report, track accepted samples
    always @(posedge i_clk) begin : monitor
        t_res want;
        in_took <= in_valid && in_ch.ready;
        if (i_rst_n) begin
            if (out_ch.valid && out_ready) begin
                if (due_reports.size() == 0) begin
                    $error("result item with no report due");
                    mismatches++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("rezeroed", want.rezeroed, out_ch.rezeroed);
                    check_field("offset", want.offset, out_ch.offset);
                    check_field("sleep", want.sleep, out_ch.sleep);
                    check_field("halt", want.halt, out_ch.halt);
                    check_field("condition", want.condition, out_ch.condition);
                end
            end
            if (in_valid && in_ch.ready) begin
                void'(pending_samples.pop_front());
                track_sample(in_sample);
            end
        end
    end

    // Driver: offer the head sample, hold it until taken, idle in bursts
    always @(negedge i_clk) begin
        if (in_valid && !in_took) begin
            // offered item still waiting
        end else if (send_gap > 0) begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_samples.size() == 0) begin
            in_valid <= 1'b0;
        end else if (hold_left == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            send_gap <= $urandom_range(0, 9);
        end else begin
            in_valid  <= 1'b1;
            in_sample <= pending_samples[0];
        end
    end

    // Receiver: one long hold-off when asked, otherwise stall bursts
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (want_hold && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= LONG_HOLD - 1;
            hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic int jitter(input int amp);
        return int'($urandom_range(0, 2 * amp)) - amp;
    endfunction

    // Next sample: middle-store slots mostly near a quiet level, the rest spread
    function automatic t_word next_sample();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (gen_pos == 8'd0) begin
            noise_amp   = $urandom_range(0, 14);
            quiet_level = quiet_level + jitter(2);
        end
        if (gen_pos[5:0] == 6'd0 && pick < 75) begin
            v = quiet_level + jitter(noise_amp);
        end else if (pick < 10) begin
            case ($urandom_range(0, 3))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = 0;
                default: v = -1;
            endcase
        end else if (pick < 55) begin
            v = int'($signed(cfg_now.threshold)) + jitter(150);
        end else if (pick < 85) begin
            v = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            v = quiet_level + jitter(noise_amp);
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return t_word'(v);
    endfunction

    task automatic push_item(input t_word s);
        pending_samples.push_back(s);
        gen_pos = gen_pos + 8'd1;
    endtask

    // Wait until every sample has been taken and every report has come back
    task automatic drain();
        while (pending_samples.size() != 0 || due_reports.size() != 0) @(negedge i_clk);
        repeat (4 * RESULT_LATENCY) @(negedge i_clk);
    endtask

    // APB write: setup then access; bits above the register width are filled with junk
    task automatic write_reg(input logic [2:0] idx, input int value);
        int          width;
        logic [31:0] keep;
        logic [31:0] word;
        case (idx)
            REG_THRESHOLD, REG_MIN_LEVEL: width = 16;
            REG_HYSTERESIS:               width = 8;
            default:                      width = 15;
        endcase
        keep = (32'd1 << width) - 32'd1;
        word = (32'($urandom()) & ~keep) | (32'(value) & keep);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_THRESHOLD:   cfg_now.threshold       = word[15:0];
            REG_HYSTERESIS:  cfg_now.hysteresis      = word[7:0];
            REG_MIN_LEVEL:   cfg_now.min_level       = word[15:0];
            REG_ZERO_TOL:    cfg_now.zero_tol        = word[14:0];
            REG_SLEEP_ENTER: cfg_now.sleep_enter_tol = word[14:0];
            REG_SLEEP_EXIT:  cfg_now.sleep_exit_tol  = word[14:0];
            REG_HALT_TOL:    cfg_now.halt_tol        = word[14:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int thr, input int hyst, input int min_lvl, input int ztol,
                             input int s_enter, input int s_exit, input int htol);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_HYSTERESIS, hyst);
        write_reg(REG_MIN_LEVEL, min_lvl);
        write_reg(REG_ZERO_TOL, ztol);
        write_reg(REG_SLEEP_ENTER, s_enter);
        write_reg(REG_SLEEP_EXIT, s_exit);
        write_reg(REG_HALT_TOL, htol);
        // index past the register list: must change nothing
        write_reg(REG_SPARE, $urandom());
    endtask

    task automatic run_phase(input int pct, input int level, input bit hold);
        @(posedge i_clk);
        idle_pct    = pct;
        quiet_level = level;
        want_hold   = hold;
        repeat (PHASE_ITEMS) push_item(next_sample());
        drain();
    endtask

    // Stimulus
    initial begin : stimulus
        int thr;
        cfg_now.threshold       = '0;
        cfg_now.hysteresis      = '0;
        cfg_now.min_level       = '0;
        cfg_now.zero_tol        = ZERO_TOL_RST;
        cfg_now.sleep_enter_tol = SLEEP_ENTER_RST;
        cfg_now.sleep_exit_tol  = SLEEP_EXIT_RST;
        cfg_now.halt_tol        = HALT_TOL_RST;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // opening items at the reset settings
        @(posedge i_clk);
        idle_pct = 20;
        foreach (OPENING[k]) push_item(OPENING[k]);
        drain();

        // moderate settings; negative quiet level exercises truncation of the average
        configure(100, 20, -50, 10, 3, 10, 3);
        run_phase(30, -5, 1'b0);

        // upper extremes, with the long receiver hold-off
        configure(32767, 127, 32767, 32767, 32767, 32767, 0);
        run_phase(10, 0, 1'b1);

        // lower extremes; halt cannot set while the last slow entry is still zero
        configure(-32768, -128, -32768, 0, 0, 0, 32767);
        run_phase(40, -3, 1'b0);

        // random settings around a random threshold
        thr = int'($urandom_range(0, 4000)) - 2000;
        configure(thr, int'($urandom_range(0, 255)) - 128, thr - int'($urandom_range(0, 3000)),
                  $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(0, 15));
        run_phase(15, int'($urandom_range(0, 60)) - 30, 1'b0);

        // last part: no idling, wide halt tolerance
        thr = int'($urandom_range(0, 4000)) - 2000;
        configure(thr, int'($urandom_range(0, 255)) - 128, thr - int'($urandom_range(0, 3000)),
                  $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15), 32767);
        run_phase(0, 40 + int'($urandom_range(0, 20)), 1'b0);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### multirate_motion_tracker.f
sv/mmt_pkg.sv
sv/mmt_if.sv
sv/mmt_regs.sv
sv/mmt_core.sv
sv/multirate_motion_tracker.sv
test/testbench.sv
